// ----- rtl/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial speed command parser package
// Shared sizes, configuration codes, control and status words and the
// microprogram that steps the parser datapath.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int BUFFER_DEPTH = 8;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH);

	localparam int BYTE_W   = 8;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int LGAIN_W  = 8;
	localparam int RGAIN_W  = 16;
	localparam int MAG_W    = 14;
	localparam int SPEED_W  = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_GAIN  = 1'b0,
		REG_RIGHT_GAIN = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'd0,
		ST_DISPATCH = 4'd1,
		ST_STORE    = 4'd2,
		ST_CHECK    = 4'd3,
		ST_CMD_A    = 4'd4,
		ST_CMD_LR   = 4'd5,
		ST_FOLD     = 4'd6,
		ST_OFFSET   = 4'd7,
		ST_SCALE    = 4'd8,
		ST_PRESET   = 4'd9,
		ST_EMIT     = 4'd10
	} step_t;

	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_BEAT      = 3'd1,
		C_HASH      = 3'd2,
		C_CNT_ZERO  = 3'd3,
		C_IS_A      = 3'd4,
		C_IS_LR     = 3'd5,
		C_FOLD_DONE = 3'd6,
		C_OUT_BUSY  = 3'd7
	} cond_t;

	typedef struct packed {
		logic  accept;
		logic  store;
		logic  clr_fold;
		logic  fold;
		logic  offset;
		logic  scale;
		logic  preset;
		logic  emit;
		cond_t cond;
		step_t t_true;
		step_t t_false;
	} ctl_word_t;

	typedef struct packed {
		logic beat;
		logic is_hash;
		logic cnt_zero;
		logic is_a;
		logic is_lr;
		logic fold_done;
		logic out_busy;
	} dp_status_t;

	function automatic ctl_word_t ucode(input step_t step);
		ctl_word_t w;
		w = '0;
		w.cond    = C_ALWAYS;
		w.t_true  = ST_IDLE;
		w.t_false = ST_IDLE;
		unique case (step)
			ST_IDLE: begin
				w.accept = 1'b1;
				w.cond = C_BEAT; w.t_true = ST_DISPATCH; w.t_false = ST_IDLE;
			end
			ST_DISPATCH: begin
				w.cond = C_HASH; w.t_true = ST_CHECK; w.t_false = ST_STORE;
			end
			ST_STORE: begin
				w.store = 1'b1;
				w.t_true = ST_IDLE;
			end
			ST_CHECK: begin
				w.clr_fold = 1'b1;
				w.cond = C_CNT_ZERO; w.t_true = ST_EMIT; w.t_false = ST_CMD_A;
			end
			ST_CMD_A: begin
				w.cond = C_IS_A; w.t_true = ST_PRESET; w.t_false = ST_CMD_LR;
			end
			ST_CMD_LR: begin
				w.cond = C_IS_LR; w.t_true = ST_FOLD; w.t_false = ST_EMIT;
			end
			ST_FOLD: begin
				w.fold = 1'b1;
				w.cond = C_FOLD_DONE; w.t_true = ST_OFFSET; w.t_false = ST_FOLD;
			end
			ST_OFFSET: begin
				w.offset = 1'b1;
				w.t_true = ST_SCALE;
			end
			ST_SCALE: begin
				w.scale = 1'b1;
				w.t_true = ST_EMIT;
			end
			ST_PRESET: begin
				w.preset = 1'b1;
				w.t_true = ST_EMIT;
			end
			ST_EMIT: begin
				w.emit = 1'b1;
				w.cond = C_OUT_BUSY; w.t_true = ST_EMIT; w.t_false = ST_IDLE;
			end
			default: begin
				w.t_true = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/ssc_rx_if.sv -----
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received ASCII byte per beat.
// ----------------------------------------------------------------------------
interface ssc_rx_if;
	logic                       valid;
	logic                       ready;
	logic [ssc_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/ssc_res_if.sv -----
// ----------------------------------------------------------------------------
// Motor target channel
// Valid/ready channel that carries both directions and speeds per beat.
// ----------------------------------------------------------------------------
interface ssc_res_if;
	logic                        valid;
	logic                        ready;
	logic                        left_forward;
	logic                        right_forward;
	logic [ssc_pkg::SPEED_W-1:0] left_target;
	logic [ssc_pkg::SPEED_W-1:0] right_target;

	modport source (output valid, output left_forward, output right_forward,
		output left_target, output right_target, input ready);
	modport sink (input valid, input left_forward, input right_forward,
		input left_target, input right_target, output ready);
endinterface

// ----- rtl/ssc_sequencer.sv -----
// ----------------------------------------------------------------------------
// Parser sequencer
// Step counter that reads the microprogram and takes conditional jumps on
// the datapath status.
// ----------------------------------------------------------------------------
module ssc_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  ssc_pkg::dp_status_t stat,
	output ssc_pkg::ctl_word_t  ctl
);

	ssc_pkg::step_t step_q;
	logic           hit;

	assign ctl = ssc_pkg::ucode(step_q);

	always_comb begin
		unique case (ctl.cond)
			ssc_pkg::C_ALWAYS:    hit = 1'b1;
			ssc_pkg::C_BEAT:      hit = stat.beat;
			ssc_pkg::C_HASH:      hit = stat.is_hash;
			ssc_pkg::C_CNT_ZERO:  hit = stat.cnt_zero;
			ssc_pkg::C_IS_A:      hit = stat.is_a;
			ssc_pkg::C_IS_LR:     hit = stat.is_lr;
			ssc_pkg::C_FOLD_DONE: hit = stat.fold_done;
			ssc_pkg::C_OUT_BUSY:  hit = stat.out_busy;
			default:              hit = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ssc_pkg::ST_IDLE;
		end else begin
			step_q <= hit ? ctl.t_true : ctl.t_false;
		end
	end

	a_beat_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.beat |-> step_q == ssc_pkg::ST_IDLE)
		else $error("input beat taken outside the idle step");

	a_beat_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		stat.beat |=> step_q == ssc_pkg::ST_DISPATCH)
		else $error("input beat not followed by dispatch");

	a_scale_emit: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ssc_pkg::ST_SCALE |=> step_q == ssc_pkg::ST_EMIT)
		else $error("scale step not followed by emit");

endmodule

// ----- rtl/ssc_datapath.sv -----
// ----------------------------------------------------------------------------
// Parser datapath
// Character buffer, decimal fold, offset and gain scaling, motor state and
// the output register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module ssc_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ssc_pkg::ctl_word_t              ctl,
	output ssc_pkg::dp_status_t             stat,
	input  logic                            cfg_we,
	input  logic [ssc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssc_pkg::CFG_W-1:0]       cfg_data,
	ssc_rx_if.sink                          rx,
	ssc_res_if.source                       res
);

	localparam int CNT_W  = ssc_pkg::CNT_W;
	localparam int MAG_W  = ssc_pkg::MAG_W;
	localparam int ACC_W  = 10;
	localparam int VAL_W  = 7;
	localparam int OFF_W  = 6;
	localparam int SUM_W  = 14;
	localparam int RPROD_W = OFF_W + ssc_pkg::RGAIN_W;
	localparam int RECIP_W = 18;
	localparam int SPROD_W = MAG_W + RECIP_W;
	localparam int SPEED_SHIFT = 19;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ssc_pkg::BUFFER_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_R     = 8'h52;

	localparam logic [3:0] DIG_OTHER = 4'd10;
	localparam logic [3:0] DIG_PLUS  = 4'd11;
	localparam logic [3:0] DIG_MINUS = 4'd12;

	localparam logic [ACC_W-1:0] ACC_MAX  = ACC_W'(1000);
	localparam logic [VAL_W-1:0] VAL_MAX  = VAL_W'(99);
	localparam logic [VAL_W-1:0] VAL_MIN  = VAL_W'(1);
	localparam logic [VAL_W-1:0] VAL_MID  = VAL_W'(50);
	localparam logic [MAG_W-1:0] L_PRESET = MAG_W'(999);
	localparam logic [MAG_W-1:0] R_PRESET = MAG_W'(250);

	// floor(m * 5 / 12) == (m * 218455) >> 19 for every 14-bit m.
	localparam logic [RECIP_W-1:0] SPEED_RECIP = RECIP_W'(218455);

	function automatic logic [3:0] digit_of(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return c[3:0];
		else if (c == CH_PLUS) return DIG_PLUS;
		else if (c == CH_MINUS) return DIG_MINUS;
		else return DIG_OTHER;
	endfunction

	logic [7:0]                     buf_q [ssc_pkg::BUFFER_DEPTH];
	logic [7:0]                     rx_q;
	logic [7:0]                     cmd_q;
	logic [7:0]                     prev_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               idx_q;
	logic [ACC_W-1:0]               acc_q;
	logic                           rev_q;
	logic [OFF_W-1:0]               off_q;
	logic                           lrev_q;
	logic                           rrev_q;
	logic [MAG_W-1:0]               lmag_q;
	logic [MAG_W-1:0]               rmag_q;
	logic [ssc_pkg::LGAIN_W-1:0]    lgain_q;
	logic [ssc_pkg::RGAIN_W-1:0]    rgain_q;
	logic                           out_valid_q;
	logic                           lfwd_q;
	logic                           rfwd_q;
	logic [ssc_pkg::SPEED_W-1:0]    lspeed_q;
	logic [ssc_pkg::SPEED_W-1:0]    rspeed_q;

	logic                           beat;
	logic                           fold_fire;
	logic                           emit_fire;
	logic                           zero_pre;
	logic [SUM_W-1:0]               fold_sum;
	logic [VAL_W-1:0]               val;
	logic [MAG_W-1:0]               lprod;
	logic [RPROD_W-1:0]             rprod;
	logic [SPROD_W-1:0]             lsprod;
	logic [SPROD_W-1:0]             rsprod;

	assign beat      = rx.valid && ctl.accept;
	assign rx.ready  = ctl.accept;

	assign stat.beat      = beat;
	assign stat.is_hash   = (rx_q == CH_HASH);
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.is_a      = (cmd_q == CH_A);
	assign stat.is_lr     = (cmd_q == CH_L) || (cmd_q == CH_R);
	assign stat.fold_done = ({1'b0, idx_q} + (CNT_W+1)'(1)) >= {1'b0, cnt_q};
	assign stat.out_busy  = out_valid_q && !res.ready;

	assign fold_fire = ctl.fold && !stat.fold_done;
	assign emit_fire = ctl.emit && !stat.out_busy;

	assign fold_sum = SUM_W'(acc_q) * SUM_W'(10) + SUM_W'(digit_of(buf_q[idx_q]));

	always_comb begin
		if (acc_q > ACC_W'(VAL_MAX)) val = VAL_MAX;
		else if (acc_q == '0) val = VAL_MIN;
		else val = acc_q[VAL_W-1:0];
	end

	assign zero_pre = (cnt_q >= CNT_TWO) && (prev_q == CH_ZERO);
	assign lprod    = MAG_W'(off_q) * MAG_W'(lgain_q);
	assign rprod    = RPROD_W'(off_q) * RPROD_W'(rgain_q);
	assign lsprod   = SPROD_W'(lmag_q) * SPROD_W'(SPEED_RECIP);
	assign rsprod   = SPROD_W'(rmag_q) * SPROD_W'(SPEED_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssc_pkg::BUFFER_DEPTH; i++) begin
				buf_q[i] <= CH_ZERO;
			end
			cnt_q       <= '0;
			lrev_q      <= 1'b0;
			rrev_q      <= 1'b0;
			lmag_q      <= '0;
			rmag_q      <= '0;
			lgain_q     <= ssc_pkg::LGAIN_W'(20);
			rgain_q     <= ssc_pkg::RGAIN_W'(5120);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (ssc_pkg::cfg_reg_t'(cfg_index))
					ssc_pkg::REG_LEFT_GAIN:  lgain_q <= cfg_data[ssc_pkg::LGAIN_W-1:0];
					ssc_pkg::REG_RIGHT_GAIN: rgain_q <= cfg_data[ssc_pkg::RGAIN_W-1:0];
					default: ;
				endcase
			end
			if (ctl.store) begin
				buf_q[cnt_q] <= rx_q;
				if (cnt_q != CNT_LAST) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (ctl.scale) begin
				if (cmd_q == CH_L) begin
					lrev_q <= rev_q;
					lmag_q <= lprod;
				end else begin
					rrev_q <= rev_q;
					rmag_q <= rprod[RPROD_W-1 -: MAG_W];
				end
			end
			if (ctl.preset) begin
				lrev_q <= 1'b0;
				rrev_q <= 1'b0;
				lmag_q <= zero_pre ? '0 : L_PRESET;
				rmag_q <= zero_pre ? '0 : R_PRESET;
			end
			if (emit_fire) begin
				cnt_q       <= '0;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			rx_q <= rx.rx_byte;
		end
		if (ctl.store && cnt_q != CNT_LAST) begin
			prev_q <= cmd_q;
			cmd_q  <= rx_q;
		end
		if (ctl.clr_fold) begin
			acc_q <= '0;
			idx_q <= '0;
		end else if (fold_fire) begin
			acc_q <= (fold_sum > SUM_W'(ACC_MAX)) ? ACC_MAX : fold_sum[ACC_W-1:0];
			idx_q <= idx_q + CNT_W'(1);
		end
		if (ctl.offset) begin
			rev_q <= (val < VAL_MID);
			off_q <= (val < VAL_MID) ? OFF_W'(VAL_MID - val) : OFF_W'(val - VAL_MID);
		end
		if (emit_fire) begin
			lfwd_q   <= !lrev_q;
			rfwd_q   <= !rrev_q;
			lspeed_q <= lsprod[SPEED_SHIFT +: ssc_pkg::SPEED_W];
			rspeed_q <= rsprod[SPEED_SHIFT +: ssc_pkg::SPEED_W];
		end
	end

	assign res.valid         = out_valid_q;
	assign res.left_forward  = lfwd_q;
	assign res.right_forward = rfwd_q;
	assign res.left_target   = lspeed_q;
	assign res.right_target  = rspeed_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("character count beyond the last buffer slot");

	a_emit_result: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> out_valid_q && cnt_q == '0)
		else $error("emit did not present a beat and clear the count");

	a_fold_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.offset |-> acc_q <= ACC_MAX)
		else $error("folded value above its saturation limit");

endmodule

// ----- rtl/serial_speed_command_parser.sv -----
// ----------------------------------------------------------------------------
// Serial speed command parser
// Gathers received bytes into commands ended by '#' and presents the left
// and right motor directions and target speeds after each command.
// ----------------------------------------------------------------------------
// The rx channel takes one ASCII byte per beat; the res channel gives one beat
// with both directions and speeds for every '#' byte, and nothing for other
// bytes. The user must set the gains through the write port only while the
// block is idle; the block itself does not enforce this. A stored byte passes
// the dispatch and store steps before the block takes the next byte. A '#'
// beat passes dispatch and the checks to emit, through preset for 'A' or the
// fold, offset and scale steps for 'L' or 'R' with n value characters (at
// most 6); the fold step consumes one buffered character per cycle. Reset
// loads the default gains, clears the count and both stored motor magnitudes.
// While a result waits on res, the block keeps accepting ordinary bytes; a
// further '#' holds in its emit step until the waiting beat is taken.
// ----------------------------------------------------------------------------
module serial_speed_command_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	ssc_rx_if.sink                        rx,
	ssc_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssc_pkg::CFG_W-1:0]     cfg_data
);

	ssc_pkg::ctl_word_t  ctl;
	ssc_pkg::dp_status_t stat;

	ssc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	ssc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx),
		.res       (res)
	);

endmodule
